FILE: rtl/core/ybgc_pkg.sv
`default_nettype none

package ybgc_pkg;

  typedef enum logic [1:0] {
    MODE_BGR       = 2'd0,
    MODE_UYVY_GRAY = 2'd1,
    MODE_YUYV_GRAY = 2'd2,
    MODE_RSVD      = 2'd3
  } mode_t;

  localparam int PROD_W = 17;
  localparam int MUL_W  = 18;
  localparam int SUM_W  = 11;

  localparam logic signed [MUL_W-1:0] CB_MUL   = 18'sd454;
  localparam logic signed [MUL_W-1:0] CG_U_MUL = 18'sd88;
  localparam logic signed [MUL_W-1:0] CG_V_MUL = 18'sd183;
  localparam logic signed [MUL_W-1:0] CR_MUL   = 18'sd359;

  typedef struct packed {
    logic signed [7:0] du;
    logic signed [7:0] dv;
    logic [7:0]        y1;
    logic [7:0]        y2;
    logic [7:0]        gray1;
    logic [7:0]        gray2;
    logic              color_en;
    logic              eof;
    mode_t             mode;
  } s1_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] cb_p;
    logic signed [PROD_W-1:0] cg_p;
    logic signed [PROD_W-1:0] cr_p;
    logic [7:0]               y1;
    logic [7:0]               y2;
    logic [7:0]               gray1;
    logic [7:0]               gray2;
    logic                     color_en;
    logic                     eof;
  } s2_t;

  typedef struct packed {
    logic [7:0] first_blue;
    logic [7:0] first_green;
    logic [7:0] first_red;
    logic [7:0] second_blue;
    logic [7:0] second_green;
    logic [7:0] second_red;
    logic [7:0] first_gray;
    logic [7:0] second_gray;
    logic       frame_end;
  } res_t;

  function automatic logic [7:0] sat8(input logic signed [SUM_W-1:0] v);
    logic [7:0] r;
    if (v < 0) begin
      r = 8'd0;
    end else if (v > 11'sd255) begin
      r = 8'd255;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/ybgc_unpack.sv
`default_nettype none

module ybgc_unpack
  import ybgc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       valid_i,
  output logic            ready_o,
  input  wire logic [7:0] b0_i,
  input  wire logic [7:0] b1_i,
  input  wire logic [7:0] b2_i,
  input  wire logic [7:0] b3_i,
  input  wire logic       eof_i,
  input  wire mode_t      mode_i,
  output logic            valid_o,
  input  wire logic       ready_i,
  output s1_t             data_o
);

  logic valid_r;
  s1_t  data_r;
  s1_t  data_nxt;

  assign ready_o = !valid_r || ready_i;

  always_comb begin
    data_nxt          = '0;
    data_nxt.du       = {~b0_i[7], b0_i[6:0]};
    data_nxt.dv       = {~b2_i[7], b2_i[6:0]};
    data_nxt.y1       = b1_i;
    data_nxt.y2       = b3_i;
    data_nxt.eof      = eof_i;
    data_nxt.mode     = mode_i;
    data_nxt.color_en = (mode_i == MODE_BGR);
    unique case (mode_i)
      MODE_BGR, MODE_UYVY_GRAY: begin
        data_nxt.gray1 = b1_i;
        data_nxt.gray2 = b3_i;
      end
      MODE_YUYV_GRAY: begin
        data_nxt.gray1 = b0_i;
        data_nxt.gray2 = b2_i;
      end
      default: begin
        data_nxt.gray1 = 8'd0;
        data_nxt.gray2 = 8'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      data_r <= data_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule

`default_nettype wire

FILE: rtl/core/ybgc_chroma_mul.sv
`default_nettype none

module ybgc_chroma_mul
  import ybgc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic valid_i,
  output logic      ready_o,
  input  wire s1_t  data_i,
  output logic      valid_o,
  input  wire logic ready_i,
  output s2_t       data_o
);

  logic                    valid_r;
  s2_t                     data_r;
  s2_t                     data_nxt;
  logic signed [MUL_W-1:0] du_ext;
  logic signed [MUL_W-1:0] dv_ext;
  logic signed [MUL_W-1:0] cb_full;
  logic signed [MUL_W-1:0] cg_full;
  logic signed [MUL_W-1:0] cr_full;

  assign ready_o = !valid_r || ready_i;

  assign du_ext  = MUL_W'(data_i.du);
  assign dv_ext  = MUL_W'(data_i.dv);
  assign cb_full = du_ext * CB_MUL;
  assign cr_full = dv_ext * CR_MUL;
  assign cg_full = du_ext * CG_U_MUL + dv_ext * CG_V_MUL;

  always_comb begin
    data_nxt          = '0;
    data_nxt.cb_p     = cb_full[PROD_W-1:0];
    data_nxt.cg_p     = cg_full[PROD_W-1:0];
    data_nxt.cr_p     = cr_full[PROD_W-1:0];
    data_nxt.y1       = data_i.y1;
    data_nxt.y2       = data_i.y2;
    data_nxt.gray1    = data_i.gray1;
    data_nxt.gray2    = data_i.gray2;
    data_nxt.color_en = data_i.color_en;
    data_nxt.eof      = data_i.eof;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      data_r <= data_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule

`default_nettype wire

FILE: rtl/core/ybgc_pixel_out.sv
`default_nettype none

module ybgc_pixel_out
  import ybgc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic valid_i,
  output logic      ready_o,
  input  wire s2_t  data_i,
  output logic      valid_o,
  input  wire logic ready_i,
  output res_t      data_o
);

  logic                    valid_r;
  res_t                    data_r;
  res_t                    data_nxt;
  logic signed [8:0]       cb;
  logic signed [8:0]       cg;
  logic signed [8:0]       cr;
  logic signed [SUM_W-1:0] y1_ext;
  logic signed [SUM_W-1:0] y2_ext;

  assign ready_o = !valid_r || ready_i;

  // floor shift by 8
  assign cb = data_i.cb_p[PROD_W-1:8];
  assign cg = data_i.cg_p[PROD_W-1:8];
  assign cr = data_i.cr_p[PROD_W-1:8];

  assign y1_ext = $signed({3'b000, data_i.y1});
  assign y2_ext = $signed({3'b000, data_i.y2});

  always_comb begin
    data_nxt             = '0;
    data_nxt.first_gray  = data_i.gray1;
    data_nxt.second_gray = data_i.gray2;
    data_nxt.frame_end   = data_i.eof;
    if (data_i.color_en) begin
      data_nxt.first_blue   = sat8(y1_ext + SUM_W'(cb));
      data_nxt.first_green  = sat8(y1_ext - SUM_W'(cg));
      data_nxt.first_red    = sat8(y1_ext + SUM_W'(cr));
      data_nxt.second_blue  = sat8(y2_ext + SUM_W'(cb));
      data_nxt.second_green = sat8(y2_ext - SUM_W'(cg));
      data_nxt.second_red   = sat8(y2_ext + SUM_W'(cr));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      data_r <= data_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule

`default_nettype wire

FILE: rtl/core/yuv422_to_bgr_gray_converter.sv
// 4:2:2 macropixel converter, UYVY/YUYV in, BGR pair or gray pair out.
// Input channel: in_valid/in_ready plus four bytes and an end-of-frame flag;
// one macropixel (two pixels) moves per transfer.
// Output channel: out_valid/out_ready plus six saturated color bytes, two
// gray bytes and the frame-end copy; exactly one result per input transfer.
// cfg_write_en/cfg_write_data set the output mode (0 BGR, 1 UYVY gray,
// 2 YUYV gray, 3 all zero); write it only while the pipe is empty.
// Each item carries the mode it saw when it was taken in.
// Pipeline: three register stages (unpack, chroma multiply, add and
// saturate). The third stage is the output register, so each item passes
// through the unpack, multiply and output registers before it leaves.
// Throughput: one macropixel per cycle, set by the three stage registers
// each loading every cycle while the receiver takes results.
// Reset clears all stage valid bits and sets the mode to 0.
// When out_ready is low, stages fill up one by one; in_ready drops once
// all three hold an item, and it rises in the same cycle out_ready does.
// Nothing is dropped or repeated under any stall pattern.
`default_nettype none

module yuv422_to_bgr_gray_converter
  import ybgc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_first_byte,
  input  wire logic [7:0] in_second_byte,
  input  wire logic [7:0] in_third_byte,
  input  wire logic [7:0] in_fourth_byte,
  input  wire logic       in_end_of_frame,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_first_blue,
  output logic [7:0]      out_first_green,
  output logic [7:0]      out_first_red,
  output logic [7:0]      out_second_blue,
  output logic [7:0]      out_second_green,
  output logic [7:0]      out_second_red,
  output logic [7:0]      out_first_gray,
  output logic [7:0]      out_second_gray,
  output logic            out_frame_end_out,
  input  wire logic       cfg_write_en,
  input  wire logic [1:0] cfg_write_data
);

  mode_t mode_r;
  logic  s1_valid;
  logic  s1_ready;
  s1_t   s1_data;
  logic  s2_valid;
  logic  s2_ready;
  s2_t   s2_data;
  res_t  res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_BGR;
    end else if (cfg_write_en) begin
      mode_r <= mode_t'(cfg_write_data);
    end
  end

  ybgc_unpack u_unpack (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (in_valid),
    .ready_o (in_ready),
    .b0_i    (in_first_byte),
    .b1_i    (in_second_byte),
    .b2_i    (in_third_byte),
    .b3_i    (in_fourth_byte),
    .eof_i   (in_end_of_frame),
    .mode_i  (mode_r),
    .valid_o (s1_valid),
    .ready_i (s1_ready),
    .data_o  (s1_data)
  );

  ybgc_chroma_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .data_i  (s1_data),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .data_o  (s2_data)
  );

  ybgc_pixel_out u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (s2_valid),
    .ready_o (s2_ready),
    .data_i  (s2_data),
    .valid_o (out_valid),
    .ready_i (out_ready),
    .data_o  (res)
  );

  assign out_first_blue    = res.first_blue;
  assign out_first_green   = res.first_green;
  assign out_first_red     = res.first_red;
  assign out_second_blue   = res.second_blue;
  assign out_second_green  = res.second_green;
  assign out_second_red    = res.second_red;
  assign out_first_gray    = res.first_gray;
  assign out_second_gray   = res.second_gray;
  assign out_frame_end_out = res.frame_end;

`ifndef SYNTH
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid && s2_valid && out_valid && !out_ready))
    else $error("in_ready low while pipe not full and stalled");

  a_mode_reset: assert property (@(posedge clk)
    !rst_n |=> (mode_r == MODE_BGR))
    else $error("mode not cleared by reset");

  a_rsvd_gray_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid && (s1_data.mode == MODE_RSVD)) |->
      (s1_data.gray1 == 8'd0 && s1_data.gray2 == 8'd0))
    else $error("reserved mode gave nonzero gray");

  a_gray_no_color: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid && s2_ready && !s2_data.color_en) |=>
      (res.first_blue == 8'd0 && res.first_green == 8'd0 && res.first_red == 8'd0 &&
       res.second_blue == 8'd0 && res.second_green == 8'd0 &&
       res.second_red == 8'd0))
    else $error("color output outside color mode");
`endif

endmodule

`default_nettype wire
